[hw/rtl/ihex_pkg.sv]
package ihex_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] START_CODE    = 8'h3A;
    localparam int         ASCII_MIN_LEN = 11;
    localparam int         BIN_OVERHEAD  = 6;

    localparam logic [7:0] RESET_MAX_TYPE = 8'd5;

    localparam int PADDR_WIDTH = 3;

    typedef enum logic [0:0] {
        REG_ASCII_MODE = 1'b0,
        REG_MAX_TYPE   = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_BAD_CSUM  = 3'd4
    } status_t;

    // Non-hex characters decode as zero.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= "0" && c <= "9")
            begin
                d = c - 8'h30;
            end
            else if (c >= "A" && c <= "F")
            begin
                d = c - 8'h37;
            end
            else if (c >= "a" && c <= "f")
            begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

endpackage

[hw/rtl/intel_hex_record_parser.sv]
// Hex-record parser. Takes one word per cycle on s_* (a character in ASCII
// mode, a raw byte in binary mode, tlast on the record's final word). Each word
// passes an input register and a combinational decode into the output register,
// and a new word is taken every cycle while m_tready is high; a stalled output
// holds both stages. Data bytes come out with m_tuser low; the final word
// gives one status word (m_tuser high) and clears the record state. Record
// state is held between words, so stalls never change results.
module intel_hex_record_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    input  logic        s_tlast,    // last_char

    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte[7:0], data_index[15:8], status[18:16], hdr_length[26:19],
    // load_address[42:27], hdr_type[50:43], checksum_field[58:51], zero pad
    output logic [63:0] m_tdata,
    output logic        m_tuser,    // is_status

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ihex_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CW = ihex_pkg::COUNT_WIDTH;

    // configuration
    logic       ascii_mode_reg;
    logic [7:0] max_type_reg;
    logic       cfg_write;
    ihex_pkg::reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = ihex_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_mode_reg <= 1'b1;
            max_type_reg   <= ihex_pkg::RESET_MAX_TYPE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ihex_pkg::REG_ASCII_MODE: ascii_mode_reg <= pwdata[0];
                ihex_pkg::REG_MAX_TYPE:   max_type_reg   <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            ihex_pkg::REG_ASCII_MODE: prdata = {31'd0, ascii_mode_reg};
            ihex_pkg::REG_MAX_TYPE:   prdata = {24'd0, max_type_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       out_valid_reg;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // record state
    logic [CW-1:0] count_reg,   count_next;
    logic          start_ok_reg, start_ok_next;
    logic [7:0]    length_reg,  length_next;
    logic [15:0]   address_reg, address_next;
    logic [7:0]    type_reg,    type_next;
    logic [7:0]    sum_reg,     sum_next;
    logic [3:0]    nibble_reg,  nibble_next;
    logic [7:0]    prev_reg,    prev_next;

    // decode
    logic          have_byte;
    logic [7:0]    dbyte;
    logic [CW-1:0] kpos;
    logic [CW-1:0] kdata;
    logic          have_data;
    logic [7:0]    chk;
    logic [CW:0]   len;
    logic [CW:0]   ascii_n;
    logic [CW:0]   bin_n;
    ihex_pkg::status_t status;
    logic          has_result;
    logic [63:0]   result_data;

    always_comb
    begin
        have_byte = 1'b0;
        dbyte     = in_byte_reg;
        kpos      = count_reg - CW'(1);
        if (count_reg != '0)
        begin
            if (ascii_mode_reg)
            begin
                have_byte = ~count_reg[0];
                dbyte     = {nibble_reg, ihex_pkg::hex_digit(in_byte_reg)};
                kpos      = (count_reg >> 1) - CW'(1);
            end
            else
            begin
                have_byte = 1'b1;
            end
        end
    end

    assign kdata = kpos - CW'(4);

    always_comb
    begin
        start_ok_next = start_ok_reg;
        length_next   = length_reg;
        address_next  = address_reg;
        type_next     = type_reg;
        sum_next      = sum_reg;
        nibble_next   = nibble_reg;
        have_data     = 1'b0;

        if (count_reg == '0)
        begin
            start_ok_next = (in_byte_reg == ihex_pkg::START_CODE);
        end
        else if (ascii_mode_reg && count_reg[0])
        begin
            nibble_next = ihex_pkg::hex_digit(in_byte_reg);
        end

        if (have_byte)
        begin
            priority if (kpos == CW'(0))
            begin
                length_next = dbyte;
                sum_next    = sum_reg + dbyte;
            end
            else if (kpos == CW'(1))
            begin
                address_next[15:8] = dbyte;
                sum_next           = sum_reg + dbyte;
            end
            else if (kpos == CW'(2))
            begin
                address_next[7:0] = dbyte;
                sum_next          = sum_reg + dbyte;
            end
            else if (kpos == CW'(3))
            begin
                type_next = dbyte;
                sum_next  = sum_reg + dbyte;
            end
            else if (kdata < {{(CW-8){1'b0}}, length_reg})
            begin
                have_data = 1'b1;
                sum_next  = sum_reg + dbyte;
            end
            else
            begin
                have_data = 1'b0;
            end
        end
    end

    // end-of-record checks use the state as updated by the final word
    assign len     = {1'b0, count_reg} + (CW+1)'(1);
    assign ascii_n = (len - (CW+1)'(ihex_pkg::ASCII_MIN_LEN)) >> 1;
    assign bin_n   = len - (CW+1)'(ihex_pkg::BIN_OVERHEAD);
    assign chk     = ascii_mode_reg
                   ? {ihex_pkg::hex_digit(prev_reg), ihex_pkg::hex_digit(in_byte_reg)}
                   : in_byte_reg;

    always_comb
    begin
        status = ihex_pkg::ST_OK;
        if (ascii_mode_reg)
        begin
            priority if (len < (CW+1)'(ihex_pkg::ASCII_MIN_LEN))
                status = ihex_pkg::ST_BAD_LEN;
            else if (!start_ok_next)
                status = ihex_pkg::ST_BAD_START;
            else if ({{(CW-7){1'b0}}, length_next} != ascii_n)
                status = ihex_pkg::ST_BAD_LEN;
            else
                status = ihex_pkg::ST_OK;
        end
        else
        begin
            priority if (!start_ok_next)
                status = ihex_pkg::ST_BAD_START;
            else if (len < (CW+1)'(ihex_pkg::BIN_OVERHEAD)
                     || {{(CW-7){1'b0}}, length_next} != bin_n)
                status = ihex_pkg::ST_BAD_LEN;
            else
                status = ihex_pkg::ST_OK;
        end
        if (status == ihex_pkg::ST_OK && type_next > max_type_reg)
            status = ihex_pkg::ST_BAD_TYPE;
        if (status == ihex_pkg::ST_OK && (8'd0 - sum_next) != chk)
            status = ihex_pkg::ST_BAD_CSUM;
    end

    always_comb
    begin
        if (in_last_reg)
        begin
            has_result  = 1'b1;
            result_data = {5'd0, chk, type_next, address_next, length_next,
                           status, 8'd0, 8'd0};
        end
        else
        begin
            has_result  = have_data;
            result_data = {48'd0, kdata[7:0], dbyte};
        end
    end

    always_comb
    begin
        if (in_last_reg)
        begin
            count_next = '0;
            prev_next  = 8'd0;
        end
        else
        begin
            count_next = (count_reg == ihex_pkg::COUNT_MAX) ? count_reg
                                                            : count_reg + CW'(1);
            prev_next  = in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            start_ok_reg <= 1'b0;
            length_reg   <= 8'd0;
            address_reg  <= 16'd0;
            type_reg     <= 8'd0;
            sum_reg      <= 8'd0;
            nibble_reg   <= 4'd0;
            prev_reg     <= 8'd0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            prev_reg  <= prev_next;
            if (in_last_reg)
            begin
                start_ok_reg <= 1'b0;
                length_reg   <= 8'd0;
                address_reg  <= 16'd0;
                type_reg     <= 8'd0;
                sum_reg      <= 8'd0;
                nibble_reg   <= 4'd0;
            end
            else
            begin
                start_ok_reg <= start_ok_next;
                length_reg   <= length_next;
                address_reg  <= address_next;
                type_reg     <= type_next;
                sum_reg      <= sum_next;
                nibble_reg   <= nibble_next;
            end
        end
    end

    // output register
    logic [63:0] out_data_reg;
    logic        out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= has_result;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_data_reg <= result_data;
            out_user_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
